// File: rtl/text_tokenizer_with_comments_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// Depends on nothing; included by the modules that check their own logic.
`ifndef TEXT_TOKENIZER_WITH_COMMENTS_ASSERT_SVH
`define TEXT_TOKENIZER_WITH_COMMENTS_ASSERT_SVH

`ifndef SYNTHESIS

`define TTOK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer check failed");

`define TTOK_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");

`else

`define TTOK_ASSERT(label, clk, rst_n, prop)

`define TTOK_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/ttok_pkg.sv
// Types, constants and helper functions for the text tokenizer.
// Used by the scanner, the result queue and the top level.
`default_nettype none

package ttok_pkg;

    localparam int MAX_TOKEN_LEN = 1024;
    // The length counter saturates at MAX_TOKEN_LEN, so it must hold that value.
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    localparam int MAX_RES = 3;
    localparam int CNT_W = $clog2(MAX_RES + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4,
        MODE_WORD       = 3'd5,
        MODE_QUOTE      = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_KEPT    = 2'd1,
        KIND_DISCARD = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        logic       quoted;
        logic       last;
    } res_t;

    // Results of one input word, all pushed into the queue in the same cycle.
    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        res_t [MAX_RES-1:0]     res;
    } push_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c <= CH_SPACE) || c[7];
    endfunction

    function automatic res_t mk_res(input kind_t kind, input logic [7:0] c,
                                    input logic q);
        res_t r;
        r.kind = kind;
        r.out_char = (kind == KIND_CHAR) ? c : CH_NUL;
        r.quoted = q;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ttok_if.sv
// Valid/ready channel interfaces for the text tokenizer.
// ttok_in_if carries text bytes, ttok_out_if carries token results.
`default_nettype none

interface ttok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_data;

    modport source (output valid, output ch, output end_of_data, input ready);
    modport sink (input valid, input ch, input end_of_data, output ready);
endinterface

interface ttok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       quoted;
    logic       last;

    modport source (output valid, output kind, output out_char, output quoted,
                    output last, input ready);
    modport sink (input valid, input kind, input out_char, input quoted,
                  input last, output ready);
endinterface

`default_nettype wire

// File: rtl/ttok_scan.sv
// Input register and scanner state machine of the text tokenizer.
// Depends on ttok_pkg, ttok_in_if and the assertion macro header.
`default_nettype none

module ttok_scan (
    input  logic            clk,
    input  logic            rst_n,
    ttok_in_if.sink         text,
    input  logic            room,
    output ttok_pkg::push_t push
);
    import ttok_pkg::*;

    `include "text_tokenizer_with_comments_assert.svh"

    logic             vld_reg;
    logic             vld_next;
    logic [7:0]       ch_reg;
    logic             end_reg;
    mode_t            mode_reg;
    mode_t            mode_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;

    logic             process;
    logic             take;
    logic             end_w;
    logic             sp;
    logic             below_max;
    logic             below_str;
    kind_t            word_kind;
    logic [CNT_W-1:0] cnt_raw;
    res_t [MAX_RES-1:0] res_raw;

    // A held word is worked off once the queue can take a full burst of results.
    assign process = vld_reg && room;
    assign text.ready = !vld_reg || process;
    assign take = text.valid && text.ready;

    // A NUL byte ends the data just like the end flag.
    assign end_w = end_reg || (ch_reg == CH_NUL);
    assign sp = is_space(ch_reg);
    assign below_max = len_reg < LEN_W'(MAX_TOKEN_LEN);
    assign below_str = len_reg < LEN_W'(MAX_TOKEN_LEN - 1);
    assign word_kind = below_max ? KIND_KEPT : KIND_DISCARD;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (process)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg <= text.ch;
            end_reg <= text.end_of_data;
        end
    end

    // Next state of the scanner.
    always_comb
    begin
        mode_next = mode_reg;
        len_next = len_reg;
        if (end_w)
        begin
            mode_next = MODE_IDLE;
            len_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (ch_reg == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (ch_reg == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else if (sp)
                    begin
                        // The lone slash is a complete one-character word.
                        mode_next = MODE_IDLE;
                        len_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_WORD;
                        len_next = LEN_W'(2);
                    end
                end
                MODE_LINE:
                begin
                    if (ch_reg == CH_NEWLINE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK:
                begin
                    if (ch_reg == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR:
                begin
                    if (ch_reg == CH_SLASH)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (ch_reg != CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_WORD:
                begin
                    if (sp)
                    begin
                        mode_next = MODE_IDLE;
                        len_next = '0;
                    end
                    else if (below_max)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                MODE_QUOTE:
                begin
                    if (ch_reg == CH_QUOTE)
                    begin
                        mode_next = MODE_IDLE;
                        len_next = '0;
                    end
                    else if (below_str)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    len_next = '0;
                    if (sp)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (ch_reg == CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else if (ch_reg == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTE;
                    end
                    else
                    begin
                        mode_next = MODE_WORD;
                        len_next = LEN_W'(1);
                    end
                end
            endcase
        end
    end

    // Result words caused by the held input word.
    always_comb
    begin
        res_raw = '0;
        cnt_raw = '0;
        if (end_w)
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    res_raw[0] = mk_res(KIND_CHAR, CH_SLASH, 1'b0);
                    res_raw[1] = mk_res(KIND_KEPT, CH_NUL, 1'b0);
                    res_raw[2] = mk_res(KIND_END, CH_NUL, 1'b0);
                    cnt_raw = CNT_W'(3);
                end
                MODE_WORD:
                begin
                    res_raw[0] = mk_res(word_kind, CH_NUL, 1'b0);
                    res_raw[1] = mk_res(KIND_END, CH_NUL, 1'b0);
                    cnt_raw = CNT_W'(2);
                end
                MODE_QUOTE:
                begin
                    res_raw[0] = mk_res(KIND_KEPT, CH_NUL, 1'b1);
                    res_raw[1] = mk_res(KIND_END, CH_NUL, 1'b0);
                    cnt_raw = CNT_W'(2);
                end
                default:
                begin
                    res_raw[0] = mk_res(KIND_END, CH_NUL, 1'b0);
                    cnt_raw = CNT_W'(1);
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if ((ch_reg != CH_SLASH) && (ch_reg != CH_STAR))
                    begin
                        res_raw[0] = mk_res(KIND_CHAR, CH_SLASH, 1'b0);
                        if (sp)
                        begin
                            res_raw[1] = mk_res(KIND_KEPT, CH_NUL, 1'b0);
                        end
                        else
                        begin
                            res_raw[1] = mk_res(KIND_CHAR, ch_reg, 1'b0);
                        end
                        cnt_raw = CNT_W'(2);
                    end
                end
                MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR:
                begin
                    cnt_raw = '0;
                end
                MODE_WORD:
                begin
                    if (sp)
                    begin
                        res_raw[0] = mk_res(word_kind, CH_NUL, 1'b0);
                        cnt_raw = CNT_W'(1);
                    end
                    else if (below_max)
                    begin
                        res_raw[0] = mk_res(KIND_CHAR, ch_reg, 1'b0);
                        cnt_raw = CNT_W'(1);
                    end
                end
                MODE_QUOTE:
                begin
                    if (ch_reg == CH_QUOTE)
                    begin
                        res_raw[0] = mk_res(KIND_KEPT, CH_NUL, 1'b1);
                        cnt_raw = CNT_W'(1);
                    end
                    else if (below_str)
                    begin
                        res_raw[0] = mk_res(KIND_CHAR, ch_reg, 1'b1);
                        cnt_raw = CNT_W'(1);
                    end
                end
                default:
                begin
                    if (!sp && (ch_reg != CH_SLASH) && (ch_reg != CH_QUOTE))
                    begin
                        res_raw[0] = mk_res(KIND_CHAR, ch_reg, 1'b0);
                        cnt_raw = CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        push.res = res_raw;
        for (int i = 0; i < MAX_RES; i++)
        begin
            push.res[i].last = (cnt_raw == CNT_W'(i + 1));
        end
        push.cnt = process ? cnt_raw : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg <= '0;
        end
        else if (process)
        begin
            mode_reg <= mode_next;
            len_reg <= len_next;
        end
    end

    `TTOK_ASSERT(a_end_returns_idle, clk, rst_n,
        (process && end_w) |=> (mode_reg == MODE_IDLE && len_reg == '0))
    `TTOK_NEVER(a_len_saturates, clk, rst_n, len_reg > LEN_W'(MAX_TOKEN_LEN))
    `TTOK_ASSERT(a_push_needs_room, clk, rst_n,
        (push.cnt != '0) |-> (vld_reg && room))

endmodule

`default_nettype wire

// File: rtl/ttok_resq.sv
// Four-entry result queue: takes up to three results a cycle, hands out one.
// Depends on ttok_pkg, ttok_out_if and the assertion macro header.
`default_nettype none

module ttok_resq (
    input  logic            clk,
    input  logic            rst_n,
    input  ttok_pkg::push_t push,
    output logic            room,
    ttok_out_if.source      token
);
    import ttok_pkg::*;

    `include "text_tokenizer_with_comments_assert.svh"

    res_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               pop;
    res_t               head;

    // Room for a full burst from the scanner, whatever leaves this cycle.
    assign room = count_reg <= Q_CNT_W'(Q_DEPTH - MAX_RES);
    assign pop = token.valid && token.ready;

    assign head = q_reg[rd_ptr_reg];
    assign token.valid = count_reg != '0;
    assign token.kind = head.kind;
    assign token.out_char = head.out_char;
    assign token.quoted = head.quoted;
    assign token.last = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next = count_reg + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (CNT_W'(i) < push.cnt)
            begin
                q_reg[wr_ptr_reg + Q_PTR_W'(i)] <= push.res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `TTOK_NEVER(a_no_overflow, clk, rst_n, count_reg > Q_CNT_W'(Q_DEPTH))
    `TTOK_NEVER(a_push_without_room, clk, rst_n, (push.cnt != '0) && !room)
    `TTOK_ASSERT(a_ptr_distance, clk, rst_n,
        (count_reg != Q_CNT_W'(Q_DEPTH)) |->
        (Q_PTR_W'(count_reg) == (wr_ptr_reg - rd_ptr_reg)))

endmodule

`default_nettype wire

// File: rtl/text_tokenizer_with_comments.sv
// Top level of the streaming text tokenizer.
// Depends on ttok_pkg, ttok_if, ttok_scan and ttok_resq.
`default_nettype none

// The tokenizer takes one text byte per word on the text channel and skips
// whitespace, line comments and block comments. Bare words and quoted strings
// leave on the token channel one character per word, each token closed by a
// kept or discarded marker, and the end of the data by an end marker. A byte
// that causes at most one result does not hold the input: plain text streams
// at one byte per clock while the token channel is ready. A byte that causes
// two or three results (a token end together with the end of data, or a lone
// slash being flushed) holds the input while the queue drains, as the queue
// hands out one word per cycle and the scanner only works off a byte when the
// queue has room for three. Results are offered on the token channel once
// written into the queue. No clearing pass follows reset.
module text_tokenizer_with_comments (
    input  logic       clk,
    input  logic       rst_n,
    ttok_in_if.sink    text,
    ttok_out_if.source token
);
    import ttok_pkg::*;

    push_t push;
    logic  room;

    ttok_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .room  (room),
        .push  (push)
    );

    ttok_resq u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .token (token)
    );

endmodule

`default_nettype wire
